>>> src/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int unsigned CODE_DIGITS = 4;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned CodeW       = CODE_DIGITS * DigitW;
  localparam int unsigned CountW      = 3;
  localparam int unsigned SecW        = 6;
  localparam int unsigned TimeW       = 8;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [DigitW-1:0] NO_KEY     = 4'd11;
  localparam logic [CountW-1:0] DIGIT_MAX  = 3'd7;
  localparam logic [CountW-1:0] DIGIT_FULL = 3'(CODE_DIGITS);
  localparam logic [SecW-1:0]   SEC_MAX    = 6'd63;

  localparam logic [CodeW-1:0] CODE_ONE_RST   = 16'd13667;
  localparam logic [CodeW-1:0] CODE_TWO_RST   = 16'd18789;
  localparam logic [CodeW-1:0] CODE_THREE_RST = 16'd4657;
  localparam logic [SecW-1:0]  RELOCK_RST     = 6'd6;
  localparam logic [TimeW-1:0] TIMEOUT_RST    = 8'd60;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CODE_ONE       = 3'd0,
    REG_CODE_TWO       = 3'd1,
    REG_CODE_THREE     = 3'd2,
    REG_RELOCK_SECONDS = 3'd3,
    REG_ENTRY_TIMEOUT  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CHK_NONE    = 2'd0,
    CHK_GRANTED = 2'd1,
    CHK_DENIED  = 2'd2
  } check_e;

endpackage

>>> src/keypad_code_lock.sv
`timescale 1ns / 1ps
// A result enters the output register in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the input stalls only while a held result is stalled.
// All state updates are done by one pass of compare and counter logic ahead of that register.
// Reset is asynchronous and active low; it restores the default codes and timings, locks the
// door, clears the entry and loads the entry countdown with its default of 60 seconds.
module keypad_code_lock
  import kcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [DigitW-1:0]  key_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               door_open_o,
  output logic               key_accepted_o,
  output logic [1:0]         check_result_o,
  output logic               timeout_alarm_o,
  output logic [TimeW-1:0]   seconds_left_o,
  output logic [CountW-1:0]  digits_entered_o
);

  logic [CodeW-1:0]  code_one_q, code_two_q, code_three_q;
  logic [SecW-1:0]   relock_q;
  logic [TimeW-1:0]  timeout_q;

  logic [CountW-1:0] count_q, count_d;
  logic [DigitW-1:0] digits_q [CODE_DIGITS];
  logic [DigitW-1:0] digits_d [CODE_DIGITS];
  logic [SecW-1:0]   sec_q, sec_d;
  logic [TimeW-1:0]  cdown_q, cdown_d;
  logic              door_q, door_d;
  logic              accepted_d, alarm_d;
  check_e            check_d;

  logic              out_valid_q;
  logic              accepted_q, alarm_q;
  check_e            check_q;

  logic              in_fire;
  logic [CountW-1:0] count_inc;
  logic [SecW-1:0]   sec_inc;
  logic [CodeW-1:0]  entry;
  logic              match;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_one_q   <= CODE_ONE_RST;
      code_two_q   <= CODE_TWO_RST;
      code_three_q <= CODE_THREE_RST;
      relock_q     <= RELOCK_RST;
      timeout_q    <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CODE_ONE:       code_one_q   <= cfg_data_i;
        REG_CODE_TWO:       code_two_q   <= cfg_data_i;
        REG_CODE_THREE:     code_three_q <= cfg_data_i;
        REG_RELOCK_SECONDS: relock_q     <= cfg_data_i[SecW-1:0];
        REG_ENTRY_TIMEOUT:  timeout_q    <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign count_inc = (count_q < DIGIT_MAX) ? count_q + 3'd1 : count_q;
  assign sec_inc   = (sec_q < SEC_MAX) ? sec_q + 6'd1 : sec_q;

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      entry[CodeW-1-i*DigitW -: DigitW] = digits_d[i];
    end
  end

  assign match = (entry == code_one_q) || (entry == code_two_q) || (entry == code_three_q);

  always_comb begin
    count_d    = count_q;
    sec_d      = sec_q;
    cdown_d    = cdown_q;
    door_d     = door_q;
    accepted_d = 1'b0;
    alarm_d    = 1'b0;
    check_d    = CHK_NONE;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      digits_d[i] = digits_q[i];
    end
    if (op_e'(operation_i) == OP_SAMPLE) begin
      if (key_code_i != NO_KEY) begin
        accepted_d = 1'b1;
        count_d    = count_inc;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          if (count_inc == CountW'(i + 1)) begin
            digits_d[i] = key_code_i;
          end
        end
        if (count_inc == DIGIT_FULL) begin
          if (match) begin
            door_d  = 1'b1;
            sec_d   = '0;
            check_d = CHK_GRANTED;
          end else begin
            sec_d   = (relock_q != '0) ? relock_q - 6'd1 : '0;
            check_d = CHK_DENIED;
          end
        end
      end
    end else begin
      sec_d = sec_inc;
      if (sec_inc >= relock_q && count_q >= DIGIT_FULL) begin
        door_d  = 1'b0;
        sec_d   = '0;
        count_d = '0;
        cdown_d = timeout_q;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          digits_d[i] = '0;
        end
      end
      if (count_d != DIGIT_FULL) begin
        cdown_d = cdown_d - 8'd1;
        if (cdown_d == '0) begin
          alarm_d = 1'b1;
          cdown_d = timeout_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sec_q   <= '0;
      cdown_q <= TIMEOUT_RST;
      door_q  <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits_q[i] <= '0;
      end
    end else if (in_fire) begin
      count_q <= count_d;
      sec_q   <= sec_d;
      cdown_q <= cdown_d;
      door_q  <= door_d;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits_q[i] <= digits_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accepted_q <= accepted_d;
      alarm_q    <= alarm_d;
      check_q    <= check_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign door_open_o      = door_q;
  assign key_accepted_o   = accepted_q;
  assign check_result_o   = check_q;
  assign timeout_alarm_o  = alarm_q;
  assign seconds_left_o   = cdown_q;
  assign digits_entered_o = count_q;

endmodule

>>> src/kcl_checker.sv
`timescale 1ns / 1ps

module kcl_checker
  import kcl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              door_open_o,
  input logic              key_accepted_o,
  input logic [1:0]        check_result_o,
  input logic              timeout_alarm_o,
  input logic [TimeW-1:0]  seconds_left_o,
  input logic [CountW-1:0] digits_entered_o
);

  // A granted check always leaves the door open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_result_o == CHK_GRANTED |-> door_open_o)
    else $error("granted check with door locked");

  // A check happens only on the press that completes the code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_result_o != CHK_NONE |->
      key_accepted_o && digits_entered_o == DIGIT_FULL)
    else $error("check without a completing press");

  // A press and an alarm never come from the same transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(key_accepted_o && timeout_alarm_o))
    else $error("press and alarm in one result");

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(check_result_o) && $stable(seconds_left_o))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .door_open_o      (door_open_o),
  .key_accepted_o   (key_accepted_o),
  .check_result_o   (check_result_o),
  .timeout_alarm_o  (timeout_alarm_o),
  .seconds_left_o   (seconds_left_o),
  .digits_entered_o (digits_entered_o)
);

>>> tb/sv/keypad_code_lock_checker.sv
`timescale 1ns / 1ps
module keypad_code_lock_checker
  import kcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CodeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               operation_i,
  input  logic [DigitW-1:0]  key_code_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               door_open_i,
  input  logic               key_accepted_i,
  input  logic [1:0]         check_result_i,
  input  logic               timeout_alarm_i,
  input  logic [TimeW-1:0]   seconds_left_i,
  input  logic [CountW-1:0]  digits_entered_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic              door_open;
    logic              key_accepted;
    logic [1:0]        check_result;
    logic              timeout_alarm;
    logic [TimeW-1:0]  seconds_left;
    logic [CountW-1:0] digits_entered;
  } lock_result_t;

  logic [CodeW-1:0]  valid_code [3];
  logic [SecW-1:0]   relock_secs;
  logic [TimeW-1:0]  timeout_secs;

  logic [CountW-1:0] digit_cnt;
  logic [DigitW-1:0] entry [CODE_DIGITS];
  logic [SecW-1:0]   sec_cnt;
  logic [TimeW-1:0]  countdown;
  logic              door;

  lock_result_t      awaited_results [$];

  task automatic reset_lock();
    valid_code[0] = CODE_ONE_RST;
    valid_code[1] = CODE_TWO_RST;
    valid_code[2] = CODE_THREE_RST;
    relock_secs   = RELOCK_RST;
    timeout_secs  = TIMEOUT_RST;
    digit_cnt     = '0;
    for (int d = 0; d < CODE_DIGITS; d++) entry[d] = '0;
    sec_cnt       = '0;
    countdown     = TIMEOUT_RST;
    door          = 1'b0;
  endtask

  function automatic logic entry_matches(input logic [CodeW-1:0] code);
    logic hit;
    hit = 1'b1;
    for (int d = 0; d < CODE_DIGITS; d++) begin
      if (code[DigitW*(CODE_DIGITS-1-d) +: DigitW] != entry[d]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic lock_result_t lock_step(input op_e op, input logic [DigitW-1:0] key);
    lock_result_t r;
    r.key_accepted  = 1'b0;
    r.check_result  = CHK_NONE;
    r.timeout_alarm = 1'b0;
    if (op == OP_SAMPLE) begin
      if (key != NO_KEY) begin
        r.key_accepted = 1'b1;
        if (digit_cnt < DIGIT_MAX) digit_cnt = digit_cnt + 1'b1;
        if (digit_cnt >= 1 && digit_cnt <= DIGIT_FULL) entry[digit_cnt - 1] = key;
        if (digit_cnt == DIGIT_FULL) begin
          if (entry_matches(valid_code[0]) || entry_matches(valid_code[1]) ||
              entry_matches(valid_code[2])) begin
            door           = 1'b1;
            sec_cnt        = '0;
            r.check_result = CHK_GRANTED;
          end else begin
            sec_cnt        = (relock_secs != '0) ? relock_secs - 1'b1 : '0;
            r.check_result = CHK_DENIED;
          end
        end
      end
    end else begin
      if (sec_cnt < SEC_MAX) sec_cnt = sec_cnt + 1'b1;
      if (sec_cnt >= relock_secs && digit_cnt >= DIGIT_FULL) begin
        door      = 1'b0;
        sec_cnt   = '0;
        digit_cnt = '0;
        for (int d = 0; d < CODE_DIGITS; d++) entry[d] = '0;
        countdown = timeout_secs;
      end
      if (digit_cnt != DIGIT_FULL) begin
        countdown = countdown - 1'b1;
        if (countdown == '0) begin
          r.timeout_alarm = 1'b1;
          countdown       = timeout_secs;
        end
      end
    end
    r.door_open      = door;
    r.seconds_left   = countdown;
    r.digits_entered = digit_cnt;
    return r;
  endfunction

  task automatic note_failure(input string what, input logic has_want,
                              input lock_result_t want, input lock_result_t got);
    if (fail_count_o < 10) begin
      if (has_want) begin
        $display("%0t: %s: expected door=%0d acc=%0d chk=%0d alarm=%0d secs=%0d digits=%0d",
                 $realtime, what, want.door_open, want.key_accepted, want.check_result,
                 want.timeout_alarm, want.seconds_left, want.digits_entered);
      end else begin
        $display("%0t: %s", $realtime, what);
      end
      $display("%0t:   actual door=%0d acc=%0d chk=%0d alarm=%0d secs=%0d digits=%0d",
               $realtime, got.door_open, got.key_accepted, got.check_result,
               got.timeout_alarm, got.seconds_left, got.digits_entered);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    reset_lock();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lock_result_t got;
    lock_result_t want;
    if (!rst_ni) begin
      reset_lock();
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{door_open:      door_open_i,
                key_accepted:   key_accepted_i,
                check_result:   check_result_i,
                timeout_alarm:  timeout_alarm_i,
                seconds_left:   seconds_left_i,
                digits_entered: digits_entered_i};
        if (awaited_results.size() == 0) begin
          note_failure("result transaction with nothing expected", 1'b0, got, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) note_failure("result mismatch", 1'b1, want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CODE_ONE:       valid_code[0] = cfg_data_i;
          REG_CODE_TWO:       valid_code[1] = cfg_data_i;
          REG_CODE_THREE:     valid_code[2] = cfg_data_i;
          REG_RELOCK_SECONDS: relock_secs   = cfg_data_i[SecW-1:0];
          REG_ENTRY_TIMEOUT:  timeout_secs  = cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(lock_step(op_e'(operation_i), key_code_i));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

>>> tb/sv/keypad_code_lock_tb.sv
`timescale 1ns / 1ps
module keypad_code_lock_tb;
  import kcl_pkg::*;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CodeW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               operation_i = 1'b0;
  logic [DigitW-1:0]  key_code_i  = '0;
  logic               out_stall_i = 1'b0;

  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               door_open_o;
  logic               key_accepted_o;
  logic [1:0]         check_result_o;
  logic               timeout_alarm_o;
  logic [TimeW-1:0]   seconds_left_o;
  logic [CountW-1:0]  digits_entered_o;

  int                 fail_count;
  int                 pending;
  int                 send_idle  = 26;
  int                 recv_idle  = 62;
  int                 items_sent = 0;
  int                 phase_start;

  logic [CodeW-1:0]   code_set [3];
  logic [SecW-1:0]    relock_set;
  logic [TimeW-1:0]   timeout_set;

  keypad_code_lock dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .key_code_i       (key_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .door_open_o      (door_open_o),
    .key_accepted_o   (key_accepted_o),
    .check_result_o   (check_result_o),
    .timeout_alarm_o  (timeout_alarm_o),
    .seconds_left_o   (seconds_left_o),
    .digits_entered_o (digits_entered_o)
  );

  keypad_code_lock_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .key_code_i       (key_code_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .door_open_i      (door_open_o),
    .key_accepted_i   (key_accepted_o),
    .check_result_i   (check_result_o),
    .timeout_alarm_i  (timeout_alarm_o),
    .seconds_left_i   (seconds_left_o),
    .digits_entered_i (digits_entered_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  task automatic send_item(input op_e op, input logic [DigitW-1:0] key);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_code_i  <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CodeW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CodeW-1:0] c1, input logic [CodeW-1:0] c2,
                              input logic [CodeW-1:0] c3, input logic [SecW-1:0] relock,
                              input logic [TimeW-1:0] timeout);
    wait_drained();
    write_reg(REG_CODE_ONE, c1);
    write_reg(REG_CODE_TWO, c2);
    write_reg(REG_CODE_THREE, c3);
    write_reg(REG_RELOCK_SECONDS, CodeW'(relock));
    write_reg(REG_ENTRY_TIMEOUT, CodeW'(timeout));
    cfg_valid_i <= 1'b0;
    code_set[0] = c1;
    code_set[1] = c2;
    code_set[2] = c3;
    relock_set  = relock;
    timeout_set = timeout;
  endtask

  task automatic run_sequence();
    int                pick;
    int                extra;
    logic [CodeW-1:0]  code;
    logic [DigitW-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      code = code_set[$urandom_range(0, 2)];
      for (int d = 0; d < CODE_DIGITS; d++) begin
        key = code[DigitW*(CODE_DIGITS-1-d) +: DigitW];
        if (pick >= 55 || $urandom_range(0, 9) == 0) key = DigitW'($urandom_range(0, 15));
        if (key == NO_KEY) key = DigitW'($urandom_range(0, 10));
        if ($urandom_range(0, 99) < 30) begin
          if ($urandom_range(0, 1) == 1) send_item(OP_TICK, DigitW'($urandom));
          else send_item(OP_SAMPLE, NO_KEY);
        end
        send_item(OP_SAMPLE, key);
      end
      extra = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
      repeat (extra) begin
        key = DigitW'($urandom_range(0, 15));
        if (key == NO_KEY) key = '0;
        send_item(OP_SAMPLE, key);
      end
      repeat ($urandom_range(0, relock_set + 2)) send_item(OP_TICK, DigitW'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_item(op_e'($urandom_range(0, 1)), DigitW'($urandom));
      end
    end
  endtask

  initial begin
    code_set[0] = CODE_ONE_RST;
    code_set[1] = CODE_TWO_RST;
    code_set[2] = CODE_THREE_RST;
    relock_set  = RELOCK_RST;
    timeout_set = TIMEOUT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_SAMPLE, NO_KEY);
    send_item(OP_TICK, 4'd15);
    send_item(OP_SAMPLE, 4'd3);
    send_item(OP_SAMPLE, 4'd5);
    send_item(OP_SAMPLE, 4'd6);
    send_item(OP_SAMPLE, 4'd3);
    send_item(OP_SAMPLE, 4'd15);
    send_item(OP_SAMPLE, 4'd12);
    send_item(OP_SAMPLE, 4'd14);
    send_item(OP_SAMPLE, 4'd0);
    repeat (6) send_item(OP_TICK, NO_KEY);
    send_item(OP_SAMPLE, 4'd10);
    send_item(OP_SAMPLE, 4'd0);
    send_item(OP_SAMPLE, 4'd13);
    send_item(OP_SAMPLE, 4'd4);
    send_item(OP_TICK, 4'd0);
    send_item(OP_SAMPLE, 4'd1);
    send_item(OP_SAMPLE, 4'd2);
    send_item(OP_SAMPLE, 4'd3);
    send_item(OP_SAMPLE, 4'd1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_config(CodeW'($urandom), CodeW'($urandom), CodeW'($urandom), 6'd1, 8'd1);
        1: apply_config(16'h0000, 16'hFFFF, CodeW'($urandom), 6'd63, 8'd255);
        2: apply_config(CodeW'($urandom), CodeW'($urandom), CodeW'($urandom), 6'd0, 8'd0);
        default: apply_config(CodeW'($urandom), CodeW'($urandom), CodeW'($urandom),
                              SecW'($urandom_range(1, 10)), TimeW'($urandom_range(1, 30)));
      endcase
      if (p < 2) begin
        send_idle = 26;
        recv_idle = 62;
      end else if (p < 4) begin
        send_idle = 62;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 234) run_sequence();
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("keypad_code_lock_tb: PASS");
    end else begin
      $display("keypad_code_lock_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("keypad_code_lock_tb: FAIL");
    $finish;
  end

endmodule

>>> keypad_code_lock.f
src/kcl_pkg.sv
src/keypad_code_lock.sv
src/kcl_checker.sv
tb/sv/keypad_code_lock_checker.sv
tb/sv/keypad_code_lock_tb.sv
